// ===== sv/hypotrochoid_xy_generator_macros.svh =====
// Assertion helpers used by the checker of this block
`ifndef HYPOTROCHOID_XY_GENERATOR_MACROS_SVH
`define HYPOTROCHOID_XY_GENERATOR_MACROS_SVH

// Property checked only while out of reset
`define HXY_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property that also covers the reset cycles
`define HXY_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== sv/hxy_pkg.sv =====
package hxy_pkg;

    localparam int ATAN_LEN = 24;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

    // Datapath operations
    localparam logic [3:0] OP_IDLE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_GCD   = 4'd2;
    localparam logic [3:0] OP_MUL   = 4'd3;
    localparam logic [3:0] OP_DIVLD = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_CLD   = 4'd6;
    localparam logic [3:0] OP_CORD  = 4'd7;
    localparam logic [3:0] OP_CST   = 4'd8;
    localparam logic [3:0] OP_ACC   = 4'd9;
    localparam logic [3:0] OP_FAULT = 4'd10;

    // Output accumulation phases
    localparam logic [5:0] ACC_X_COS = 6'd0;
    localparam logic [5:0] ACC_X_PEN = 6'd1;
    localparam logic [5:0] ACC_X_SUM = 6'd2;
    localparam logic [5:0] ACC_Y_PEN = 6'd3;
    localparam logic [5:0] ACC_Y_SUM = 6'd4;

    typedef struct packed {
        logic [3:0] op;
        logic       sel;       // 0: first angle, 1: second angle
        logic [5:0] idx;       // step counter
        logic       out_load;
    } hxy_cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic fault;
    } hxy_sts_t;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051D;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2E;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F;
            5'd19: r = 32'h00000517;
            5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145;
            5'd22: r = 32'h000000A2;
            5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    // Round Q.38 to Q.8 half up, then saturate to 19 bits
    function automatic logic signed [18:0] sat_out(input logic signed [51:0] acc);
        logic signed [52:0] t;
        logic signed [22:0] v;
        logic signed [18:0] r;
        t = {acc[51], acc} + 53'sd536870912;
        v = t[52:30];
        if (v > 23'sd262143) begin
            r = 19'sd262143;
        end else if (v < -23'sd262144) begin
            r = -19'sd262144;
        end else begin
            r = v[18:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/hypotrochoid_xy_generator.sv =====
// From input transfer to m_tvalid the sequencer runs the subtractive gcd loop, then for each
// of two angles a multiply, the restoring divider and an N-step CORDIC, N = min(CORDIC_STEPS, 24),
// then the output accumulation and load. One item at a time: the next input is accepted in
// the cycle after the result loads, and a result that m_tready holds delays that load.
// A zero rolling radius or divisor skips the divider and the CORDIC: the sequencer goes
// through the fault state straight to the output load.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_tvalid.
module hypotrochoid_xy_generator #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // drive_phase[15:0], fixed_radius[31:16], rolling_radius[47:32], pen_distance[63:48]
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // x_out[18:0], y_out[37:19], zero pad[39:38]
    output logic [39:0] m_tdata,
    // fault[0]
    output logic        m_tuser
);
    import hxy_pkg::*;

    hxy_cmd_t    cmd;
    hxy_sts_t    sts;
    logic [37:0] out_data;

    hxy_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    hxy_datapath u_dp (
        .aclk      (aclk),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .out_data  (out_data),
        .out_fault (m_tuser)
    );

    assign m_tdata = {2'b00, out_data};

endmodule

// ===== sv/hxy_ctrl.sv =====
module hxy_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output hxy_pkg::hxy_cmd_t cmd,
    input  hxy_pkg::hxy_sts_t sts
);
    import hxy_pkg::*;

    localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic [5:0] LAST_CORD = 6'(NSTEPS - 1);
    localparam logic [5:0] LAST_DIV  = 6'd39;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GCD   = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_DIVLD = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_CLD   = 4'd5;
    localparam logic [3:0] S_CORD  = 4'd6;
    localparam logic [3:0] S_CST   = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_FAULT = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;
    logic       mvalid_reg, mvalid_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        sel_next     = sel_reg;
        cmd.op       = OP_IDLE;
        cmd.sel      = sel_reg;
        cmd.idx      = cnt_reg;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_GCD;
                end
            end
            S_GCD: begin
                if (sts.gcd_done) begin
                    sel_next   = 1'b0;
                    state_next = sts.fault ? S_FAULT : S_MUL;
                end else begin
                    cmd.op = OP_GCD;
                end
            end
            S_MUL: begin
                cmd.op     = OP_MUL;
                state_next = S_DIVLD;
            end
            S_DIVLD: begin
                cmd.op     = OP_DIVLD;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op   = OP_DIV;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == LAST_DIV) begin
                    state_next = S_CLD;
                end
            end
            S_CLD: begin
                cmd.op     = OP_CLD;
                cnt_next   = '0;
                state_next = S_CORD;
            end
            S_CORD: begin
                cmd.op = OP_CORD;
                if (cnt_reg == LAST_CORD) begin
                    state_next = S_CST;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_CST: begin
                cmd.op   = OP_CST;
                cnt_next = '0;
                if (sel_reg) begin
                    state_next = S_ACC;
                end else begin
                    sel_next   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_ACC: begin
                cmd.op = OP_ACC;
                if (cnt_reg == ACC_Y_SUM) begin
                    state_next = S_OUT;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            S_FAULT: begin
                cmd.op     = OP_FAULT;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the transfer completes
    always_comb begin
        if (cmd.out_load) begin
            mvalid_next = 1'b1;
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end else begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            sel_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            sel_reg    <= sel_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// ===== sv/hxy_datapath.sv =====
module hxy_datapath (
    input  logic              aclk,
    input  hxy_pkg::hxy_cmd_t cmd,
    output hxy_pkg::hxy_sts_t sts,
    input  logic [63:0]       in_data,
    output logic [37:0]       out_data,
    output logic              out_fault
);
    import hxy_pkg::*;

    localparam logic signed [32:0] QTR_TURN  = 33'sd1073741824;
    localparam logic signed [32:0] HALF_TURN = 33'sd2147483648;

    logic signed [15:0] p_reg, d_reg;
    logic [15:0]        big_reg, small_reg;
    logic [7:0]         ga_reg, gb_reg;
    logic signed [50:0] mul_reg;
    logic signed [51:0] acc_reg;
    logic [39:0]        dvd_reg;
    logic [7:0]         rem_reg;
    logic [31:0]        quo_reg;
    logic               neg_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [32:0] z_reg;
    logic               flip_reg;
    logic signed [33:0] c1_reg, s1_reg, c2_reg, s2_reg;
    logic signed [18:0] xo_reg, yo_reg;
    logic               fault_reg;
    logic signed [18:0] out_x_reg, out_y_reg;
    logic               out_fault_reg;

    logic [7:0]         m_val;
    logic signed [16:0] small_s, diff_s, d_s;
    logic signed [16:0] ma;
    logic signed [33:0] mb;
    logic signed [50:0] mul_next;
    logic signed [50:0] mag;
    logic [8:0]         trial;
    logic               ge;
    logic [31:0]        theta;
    logic signed [32:0] zs;
    logic signed [33:0] dx, dy;
    logic signed [32:0] at;

    // Divisor from the gcd registers
    assign m_val = (big_reg == 16'd256) ? 8'd1 : ((ga_reg == 8'd0) ? gb_reg : ga_reg);
    assign sts.gcd_done = (big_reg == 16'd256) || (ga_reg == 8'd0) || (gb_reg == 8'd0)
                          || (ga_reg == gb_reg);
    assign sts.fault = (small_reg == 16'd0) || (m_val == 8'd0);

    assign small_s = signed'({1'b0, small_reg});
    assign diff_s  = signed'({1'b0, big_reg}) - signed'({1'b0, small_reg});
    assign d_s     = {d_reg[15], d_reg};

    // Shared multiplier operand select
    always_comb begin
        ma = diff_s;
        mb = c1_reg;
        if (cmd.op == OP_MUL) begin
            ma = cmd.sel ? diff_s : small_s;
            mb = {{18{p_reg[15]}}, p_reg};
        end else if (cmd.op == OP_ACC) begin
            case (cmd.idx)
                ACC_X_COS: begin
                    ma = diff_s;
                    mb = c1_reg;
                end
                ACC_X_PEN: begin
                    ma = d_s;
                    mb = c2_reg;
                end
                ACC_X_SUM: begin
                    ma = diff_s;
                    mb = s1_reg;
                end
                default: begin
                    ma = d_s;
                    mb = s2_reg;
                end
            endcase
        end
    end
    assign mul_next = ma * mb;

    // Divider step and angle magnitude
    assign mag   = mul_reg[50] ? -mul_reg : mul_reg;
    assign trial = {rem_reg, dvd_reg[39]};
    assign ge    = (trial >= {1'b0, m_val});

    // Angle sign applied to the quotient
    assign theta = neg_reg ? (32'd0 - quo_reg) : quo_reg;
    assign zs    = signed'({theta[31], theta});

    // CORDIC micro-rotation terms
    assign dx = y_reg >>> cmd.idx[4:0];
    assign dy = x_reg >>> cmd.idx[4:0];
    assign at = signed'({1'b0, atan_lut(cmd.idx[4:0])});

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                p_reg     <= in_data[15:0];
                big_reg   <= in_data[31:16];
                small_reg <= in_data[47:32];
                d_reg     <= in_data[63:48];
                ga_reg    <= in_data[31:24];
                gb_reg    <= in_data[47:40];
                fault_reg <= 1'b0;
            end
            OP_GCD: begin
                if (ga_reg > gb_reg) begin
                    ga_reg <= ga_reg - gb_reg;
                end else begin
                    gb_reg <= gb_reg - ga_reg;
                end
            end
            OP_MUL: begin
                mul_reg <= mul_next;
            end
            OP_DIVLD: begin
                dvd_reg <= {mag[30:0], 9'd0};
                rem_reg <= '0;
                quo_reg <= '0;
                neg_reg <= mul_reg[50];
            end
            OP_DIV: begin
                rem_reg <= ge ? 8'(trial - {1'b0, m_val}) : trial[7:0];
                quo_reg <= {quo_reg[30:0], ge};
                dvd_reg <= {dvd_reg[38:0], 1'b0};
            end
            OP_CLD: begin
                x_reg <= CORDIC_START;
                y_reg <= '0;
                if (zs > QTR_TURN) begin
                    z_reg    <= zs - HALF_TURN;
                    flip_reg <= 1'b1;
                end else if (zs < -QTR_TURN) begin
                    z_reg    <= zs + HALF_TURN;
                    flip_reg <= 1'b1;
                end else begin
                    z_reg    <= zs;
                    flip_reg <= 1'b0;
                end
            end
            OP_CORD: begin
                if (!z_reg[32]) begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end else begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
            end
            OP_CST: begin
                if (cmd.sel) begin
                    c2_reg <= flip_reg ? -x_reg : x_reg;
                    s2_reg <= flip_reg ? -y_reg : y_reg;
                end else begin
                    c1_reg <= flip_reg ? -x_reg : x_reg;
                    s1_reg <= flip_reg ? -y_reg : y_reg;
                end
            end
            OP_ACC: begin
                mul_reg <= mul_next;
                case (cmd.idx)
                    ACC_X_PEN: acc_reg <= {mul_reg[50], mul_reg};
                    ACC_X_SUM: xo_reg  <= sat_out(acc_reg + {mul_reg[50], mul_reg});
                    ACC_Y_PEN: acc_reg <= {mul_reg[50], mul_reg};
                    ACC_Y_SUM: yo_reg  <= sat_out(acc_reg - {mul_reg[50], mul_reg});
                    default: ;
                endcase
            end
            OP_FAULT: begin
                xo_reg    <= '0;
                yo_reg    <= '0;
                fault_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_x_reg     <= xo_reg;
            out_y_reg     <= yo_reg;
            out_fault_reg <= fault_reg;
        end
    end

    assign out_data  = {out_y_reg, out_x_reg};
    assign out_fault = out_fault_reg;

endmodule

// ===== sv/hxy_checker.sv =====
`include "hypotrochoid_xy_generator_macros.svh"

module hxy_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser
);

    // Result channel empty after reset
    `HXY_ASSERT_RST(a_rst_idle, !aresetn |=> !m_tvalid, "m_tvalid high after reset")

    // One item in flight: input closes right after a transfer
    `HXY_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "s_tready held after transfer")

    // A faulted result carries zero coordinates
    `HXY_ASSERT(a_fault_zero, m_tvalid && m_tuser |-> m_tdata == 40'd0, "fault with nonzero xy")

    // Stalled result stays offered
    `HXY_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid, "m_tvalid dropped while stalled")

endmodule

bind hypotrochoid_xy_generator hxy_checker u_hxy_checker (.*);
